/* rtl/sdta_pkg.sv */
`timescale 1ns / 1ps
// shared types, control word layout and microcode program of the decimal text unit
package sdta_pkg;

	localparam int CHAR_BITS = 6;
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 6'd45;

	typedef logic [2:0] step_t;

	localparam step_t ST_WAIT   = 3'd0;
	localparam step_t ST_DABBLE = 3'd1;
	localparam step_t ST_SIGN   = 3'd2;
	localparam step_t ST_SKIP   = 3'd3;
	localparam step_t ST_DIGIT  = 3'd4;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_DABBLE,
		OP_SIGN,
		OP_SKIP,
		OP_DIGIT
	} op_t;

	typedef enum logic [2:0] {
		COND_START,
		COND_BITS_DONE,
		COND_ALWAYS,
		COND_LEAD_DONE,
		COND_DIGITS_DONE
	} cond_t;

	typedef struct packed {
		logic  busy;
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic bits_done;
		logic lead_done;
		logic digits_done;
	} dp_status_t;

	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		case (pc)
			ST_WAIT:   w = '{busy: 1'b0, op: OP_LOAD,   cond: COND_START,       target: ST_DABBLE};
			ST_DABBLE: w = '{busy: 1'b1, op: OP_DABBLE, cond: COND_BITS_DONE,   target: ST_SIGN};
			ST_SIGN:   w = '{busy: 1'b1, op: OP_SIGN,   cond: COND_ALWAYS,      target: ST_SKIP};
			ST_SKIP:   w = '{busy: 1'b1, op: OP_SKIP,   cond: COND_LEAD_DONE,   target: ST_DIGIT};
			ST_DIGIT:  w = '{busy: 1'b1, op: OP_DIGIT,  cond: COND_DIGITS_DONE, target: ST_WAIT};
			default:   w = '{busy: 1'b1, op: OP_DIGIT,  cond: COND_ALWAYS,      target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

/* rtl/sdta_sequencer.sv */
`timescale 1ns / 1ps
// step counter and microcode table with conditional jumps
module sdta_sequencer
	import sdta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ucode_t     word
);

	step_t pc_q;
	logic  jump;

	assign word = ucode_rom(pc_q);

	always_comb begin
		case (word.cond)
			COND_START:       jump = start;
			COND_BITS_DONE:   jump = status.bits_done;
			COND_ALWAYS:      jump = 1'b1;
			COND_LEAD_DONE:   jump = status.lead_done;
			COND_DIGITS_DONE: jump = status.digits_done;
			default:          jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else if (jump) begin
			pc_q <= word.target;
		end
	end

endmodule

/* rtl/sdta_datapath.sv */
`timescale 1ns / 1ps
// magnitude and bcd registers, shift-add-3 step and character output register
module sdta_datapath
	import sdta_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ucode_t                word,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output dp_status_t            status,
	output logic                  strobe,
	output logic [CHAR_BITS-1:0]  char_code,
	output logic                  last_char
);

	localparam int NDIG     = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_BITS = NDIG * 4;
	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
	localparam int DIG_BITS = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic                  neg_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [DIG_BITS-1:0]   dcnt_q;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [3:0]            top_digit;
	logic                  strobe_q;
	logic [CHAR_BITS-1:0]  char_q;
	logic                  last_q;

	assign top_digit = bcd_q[BCD_BITS-1 -: 4];

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] > 4'd4) ? bcd_q[i*4 +: 4] + 4'd3
			                                             : bcd_q[i*4 +: 4];
		end
	end

	assign status.bits_done   = (cnt_q == CNT_BITS'(1));
	assign status.digits_done = (dcnt_q == '0);
	assign status.lead_done   = (top_digit != 4'd0) || (dcnt_q == '0);

	always_ff @(posedge clk) begin
		case (word.op)
			OP_LOAD: begin
				if (start) begin
					neg_q  <= value[VALUE_BITS-1];
					mag_q  <= value[VALUE_BITS-1] ? ('0 - value) : value;
					bcd_q  <= '0;
					cnt_q  <= CNT_BITS'(VALUE_BITS);
					dcnt_q <= DIG_BITS'(NDIG - 1);
				end
			end
			OP_DABBLE: begin
				bcd_q <= {bcd_adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
			OP_SKIP: begin
				if (!status.lead_done) begin
					bcd_q  <= {bcd_q[BCD_BITS-5:0], 4'd0};
					dcnt_q <= dcnt_q - DIG_BITS'(1);
				end
			end
			OP_DIGIT: begin
				bcd_q  <= {bcd_q[BCD_BITS-5:0], 4'd0};
				dcnt_q <= dcnt_q - DIG_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (word.op == OP_DIGIT) || ((word.op == OP_SIGN) && neg_q);
		end
	end

	always_ff @(posedge clk) begin
		if (word.op == OP_DIGIT) begin
			char_q <= CH_ZERO + CHAR_BITS'(top_digit);
			last_q <= (dcnt_q == '0);
		end else begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

/* rtl/signed_int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// top level: signed integer to decimal ascii text, one character per strobe
// steps per transaction: accept, the shift-add-3 steps over the value bits, the sign step,
// the leading zero skip, then the digit steps for the remaining digit positions
// digits leave one per cycle from the output register, each in the cycle after its step
// a new transaction is taken while the last character is still on the outputs
// arst_n clears the step counter and the strobe; data registers are not reset
module signed_int_to_decimal_ascii_unit
	import sdta_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                        strobe,
	output logic [CHAR_BITS-1:0]        char_code,
	output logic                        last_char
);

	ucode_t     word;
	dp_status_t status;

	sdta_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.word   (word)
	);

	sdta_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (word),
		.start     (start),
		.value     (value),
		.status    (status),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

	assign busy = word.busy;

endmodule
